>>> rtl/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, types and the arctangent table of the haversine
// distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // angle input format
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int TURN_SHIFT      = ANGLE_FRAC_BITS + 8;

    // datapath width of the cordic units
    localparam int CW = 36;
    typedef logic signed [CW-1:0] t_cw;

    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 31;

    // cycles through each unit
    localparam int SC_LAT    = CORDIC_STEPS + 2;
    localparam int SQ_LAT    = SQRT_STEPS + 1;
    localparam int AT_LAT    = CORDIC_STEPS + 2;
    localparam int LAT_TOTAL = 2 + SC_LAT + 4 + SQ_LAT + AT_LAT + 2;

    // degrees to binary angle, 2^32 per turn
    localparam logic signed [63:0] DEG_TO_TURN_HALF = 64'sd1527099483;
    localparam logic signed [63:0] DEG_TO_TURN_FULL = 64'sd3054198966;

    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [63:0] DIST_SCALE      = 64'd5246834913;
    localparam logic [30:0] DIST_MAX        = 31'd1311708728;

    // atan(2^-i) in binary angle units
    function automatic logic [29:0] turn_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/haversine_distance.sv
// Throughput: one item per cycle; the whole pipeline holds while the output
// is stalled. Its length is set by the 28-stage cordic and 31-stage square
// root units.
// Reset: synchronous active-low i_rst_n clears all valid bits; data
// registers are not reset.
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance of two points in fixed point degrees, returned in
// km with 16 fraction bits.
// ----------------------------------------------------------------------------
module haversine_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_distance_km
);
    import hvd_pkg::*;

    logic                r_vld [0:LAT_TOTAL-1];
    logic                en;

    logic signed [63:0]  r_p_dl;
    logic signed [63:0]  r_p_do;
    logic signed [63:0]  r_p_a;
    logic signed [63:0]  r_p_b;
    logic [31:0]         r_t_dl;
    logic [31:0]         r_t_do;
    logic [31:0]         r_t_a;
    logic [31:0]         r_t_b;

    t_cw                 s_dl;
    t_cw                 c_dl;
    t_cw                 s_do;
    t_cw                 c_do;
    t_cw                 s_a;
    t_cw                 c_a;
    t_cw                 s_b;
    t_cw                 c_b;

    logic signed [71:0]  r_m_dl;
    logic signed [71:0]  r_m_do;
    logic signed [71:0]  r_m_cc;
    t_cw                 r_dl2;
    t_cw                 r_do2;
    t_cw                 r_cc;
    logic signed [71:0]  r_m_h;
    t_cw                 r_dl2_d;
    logic [30:0]         r_hav;
    logic [30:0]         r_hav_c;

    logic [30:0]         sy;
    logic [30:0]         sx;
    logic [30:0]         half_ang;
    logic [63:0]         r_dprod;
    logic [30:0]         r_dist;

    // round to binary angle, half away from zero, modulo a turn
    function automatic logic [31:0] to_turn(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (TURN_SHIFT - 1))) >> TURN_SHIFT;
        return v[63] ? 32'(-r) : r[31:0];
    endfunction

    // drop 30 fraction bits, half away from zero
    function automatic t_cw round30(input logic signed [71:0] v);
        logic [71:0] mag;
        logic [71:0] r;
        mag = v[71] ? 72'(-v) : 72'(v);
        r   = (mag + (72'd1 << 29)) >> 30;
        return v[71] ? t_cw'(-r) : t_cw'(r);
    endfunction

    // global pipeline enable
    assign en      = !r_vld[LAT_TOTAL-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[LAT_TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT_TOTAL; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < LAT_TOTAL; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // angle scaling products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dl <= 64'(signed'({i_lat_b[27], i_lat_b} - {i_lat_a[27], i_lat_a}))
                      * DEG_TO_TURN_HALF;
            r_p_do <= 64'(signed'({i_lon_b[28], i_lon_b} - {i_lon_a[28], i_lon_a}))
                      * DEG_TO_TURN_HALF;
            r_p_a  <= 64'(i_lat_a) * DEG_TO_TURN_FULL;
            r_p_b  <= 64'(i_lat_b) * DEG_TO_TURN_FULL;
        end
    end

    // binary angles
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_dl <= to_turn(r_p_dl);
            r_t_do <= to_turn(r_p_do);
            r_t_a  <= to_turn(r_p_a);
            r_t_b  <= to_turn(r_p_b);
        end
    end

    hvd_sincos u_sc_dl (.i_clk(i_clk), .i_en(en), .i_ang(r_t_dl), .o_sin(s_dl), .o_cos(c_dl));
    hvd_sincos u_sc_do (.i_clk(i_clk), .i_en(en), .i_ang(r_t_do), .o_sin(s_do), .o_cos(c_do));
    hvd_sincos u_sc_a  (.i_clk(i_clk), .i_en(en), .i_ang(r_t_a),  .o_sin(s_a),  .o_cos(c_a));
    hvd_sincos u_sc_b  (.i_clk(i_clk), .i_en(en), .i_ang(r_t_b),  .o_sin(s_b),  .o_cos(c_b));

    // haversine sum: squares and cosine product, then the cross term
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_dl  <= 72'(s_dl) * 72'(s_dl);
            r_m_do  <= 72'(s_do) * 72'(s_do);
            r_m_cc  <= 72'(c_a) * 72'(c_b);
            r_dl2   <= round30(r_m_dl);
            r_do2   <= round30(r_m_do);
            r_cc    <= round30(r_m_cc);
            r_m_h   <= 72'(r_cc) * 72'(r_do2);
            r_dl2_d <= r_dl2;
        end
    end

    // clamp to [0,1] and form the complement
    always_ff @(posedge i_clk) begin
        logic signed [CW:0] hav;
        hav = {r_dl2_d[CW-1], r_dl2_d} + (CW+1)'(round30(r_m_h));
        if (en) begin
            if (hav[CW]) begin
                r_hav   <= '0;
                r_hav_c <= ONE_Q30;
            end else if (hav > (CW+1)'(ONE_Q30)) begin
                r_hav   <= ONE_Q30;
                r_hav_c <= '0;
            end else begin
                r_hav   <= hav[30:0];
                r_hav_c <= ONE_Q30 - hav[30:0];
            end
        end
    end

    // unused sine and cosine terms
    logic unused_terms;
    assign unused_terms = ^{c_dl, c_do, s_a, s_b};

    hvd_isqrt u_sq_y (.i_clk(i_clk), .i_en(en), .i_val({r_hav, 30'd0}),   .o_root(sy));
    hvd_isqrt u_sq_x (.i_clk(i_clk), .i_en(en), .i_val({r_hav_c, 30'd0}), .o_root(sx));

    hvd_atan u_atan (.i_clk(i_clk), .i_en(en), .i_x(sx), .i_y(sy), .o_angle(half_ang));

    // scale to km, round and saturate
    always_ff @(posedge i_clk) begin
        logic [64:0] sum;
        logic [32:0] d;
        sum = {1'b0, r_dprod} + 65'h8000_0000;
        d   = sum[64:32];
        if (en) begin
            r_dprod <= {33'd0, half_ang} * DIST_SCALE;
            if (d > 33'(DIST_MAX)) begin
                r_dist <= DIST_MAX;
            end else begin
                r_dist <= d[30:0];
            end
        end
    end

    assign o_distance_km = r_dist;

endmodule

>>> rtl/hvd_sincos.sv
// ----------------------------------------------------------------------------
// hvd_sincos
// Pipelined cordic rotation: quadrant reduction, one micro-rotation per
// stage, quadrant mapping of the result.
// ----------------------------------------------------------------------------
module hvd_sincos (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [31:0]   i_ang,
    output hvd_pkg::t_cw  o_sin,
    output hvd_pkg::t_cw  o_cos
);
    import hvd_pkg::*;

    t_cw        r_x [0:CORDIC_STEPS];
    t_cw        r_y [0:CORDIC_STEPS];
    t_cw        r_z [0:CORDIC_STEPS];
    logic [1:0] r_q [0:CORDIC_STEPS];
    t_cw        n_x [0:CORDIC_STEPS];
    t_cw        n_y [0:CORDIC_STEPS];
    t_cw        n_z [0:CORDIC_STEPS];
    logic [1:0] n_q [0:CORDIC_STEPS];
    t_cw        r_sin;
    t_cw        r_cos;

    // quadrant reduction and rotation steps
    always_comb begin
        logic [31:0] sum;
        logic [31:0] ru;
        t_cw         xs;
        t_cw         ys;
        t_cw         at;
        sum    = i_ang + 32'h2000_0000;
        n_q[0] = sum[31:30];
        ru     = i_ang - {sum[31:30], 30'd0};
        n_z[0] = {{(CW-32){ru[31]}}, ru};
        n_x[0] = t_cw'(CORDIC_GAIN_Q30);
        n_y[0] = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            at = t_cw'(turn_atan(5'(i)));
            if (!r_z[i][CW-1]) begin
                n_x[i+1] = r_x[i] - ys;
                n_y[i+1] = r_y[i] + xs;
                n_z[i+1] = r_z[i] - at;
            end else begin
                n_x[i+1] = r_x[i] + ys;
                n_y[i+1] = r_y[i] - xs;
                n_z[i+1] = r_z[i] + at;
            end
            n_q[i+1] = r_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
            r_q <= n_q;
        end
    end

    // map back to the original quadrant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[CORDIC_STEPS])
                2'd0: begin
                    r_cos <= r_x[CORDIC_STEPS];
                    r_sin <= r_y[CORDIC_STEPS];
                end
                2'd1: begin
                    r_cos <= -r_y[CORDIC_STEPS];
                    r_sin <= r_x[CORDIC_STEPS];
                end
                2'd2: begin
                    r_cos <= -r_x[CORDIC_STEPS];
                    r_sin <= -r_y[CORDIC_STEPS];
                end
                default: begin
                    r_cos <= r_y[CORDIC_STEPS];
                    r_sin <= -r_x[CORDIC_STEPS];
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> rtl/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_val,
    output logic [30:0] o_root
);
    import hvd_pkg::*;

    logic [61:0] r_v [0:SQRT_STEPS];
    logic [61:0] r_r [0:SQRT_STEPS];
    logic [61:0] n_v [0:SQRT_STEPS];
    logic [61:0] n_r [0:SQRT_STEPS];

    // one trial subtraction per stage
    always_comb begin
        logic [61:0] bitv;
        logic [61:0] sum;
        n_v[0] = {1'b0, i_val};
        n_r[0] = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            bitv = 62'd1 << (60 - 2 * k);
            sum  = r_r[k] + bitv;
            if (r_v[k] >= sum) begin
                n_v[k+1] = r_v[k] - sum;
                n_r[k+1] = (r_r[k] >> 1) + bitv;
            end else begin
                n_v[k+1] = r_v[k];
                n_r[k+1] = r_r[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_r <= n_r;
        end
    end

    assign o_root = r_r[SQRT_STEPS][30:0];

endmodule

>>> rtl/hvd_atan.sv
// ----------------------------------------------------------------------------
// hvd_atan
// Pipelined cordic vectoring for the first quadrant, angle clamped to a
// quarter turn.
// ----------------------------------------------------------------------------
module hvd_atan (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    input  logic [30:0] i_y,
    output logic [30:0] o_angle
);
    import hvd_pkg::*;

    t_cw         r_x [0:CORDIC_STEPS];
    t_cw         r_y [0:CORDIC_STEPS];
    t_cw         r_z [0:CORDIC_STEPS];
    t_cw         n_x [0:CORDIC_STEPS];
    t_cw         n_y [0:CORDIC_STEPS];
    t_cw         n_z [0:CORDIC_STEPS];
    logic [30:0] r_ang;

    // vectoring steps drive y toward zero
    always_comb begin
        t_cw xs;
        t_cw ys;
        t_cw at;
        n_x[0] = t_cw'(i_x);
        n_y[0] = t_cw'(i_y);
        n_z[0] = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            at = t_cw'(turn_atan(5'(i)));
            if (!r_y[i][CW-1]) begin
                n_x[i+1] = r_x[i] + ys;
                n_y[i+1] = r_y[i] - xs;
                n_z[i+1] = r_z[i] + at;
            end else begin
                n_x[i+1] = r_x[i] - ys;
                n_y[i+1] = r_y[i] + xs;
                n_z[i+1] = r_z[i] - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // clamp to [0, quarter turn]
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_z[CORDIC_STEPS][CW-1]) begin
                r_ang <= '0;
            end else if (r_z[CORDIC_STEPS] > t_cw'(ONE_Q30)) begin
                r_ang <= ONE_Q30;
            end else begin
                r_ang <= r_z[CORDIC_STEPS][30:0];
            end
        end
    end

    assign o_angle = r_ang;

endmodule

>>> tb/hvd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hvd_checker
// Watches both channels of the haversine distance block, predicts each
// distance from the accepted coordinates and compares it with the output.
// ----------------------------------------------------------------------------
module hvd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_b,
    input  logic               o_valid,
    input  logic               o_stall,
    input  logic [30:0]        o_distance_km,
    output int                 o_errors,
    output int                 o_pending
);

    // atan(2^-i) in binary angle units
    localparam longint ATAN_TAB [28] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };
    localparam longint HALF_FACTOR = 64'sd1527099483;
    localparam longint FULL_FACTOR = 64'sd3054198966;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint UNIT_Q30    = 64'sd1073741824;

    logic [30:0] dist_queue[$];

    // floor shift
    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    // shift with rounding half away from zero
    function automatic longint rshift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0) return (v + half) >>> n;
        return -(((-v) + half) >>> n);
    endfunction

    function automatic logic [31:0] deg_to_turn(longint deg, longint factor);
        longint t;
        t = rshift(deg * factor, hvd_pkg::TURN_SHIFT);
        return t[31:0];
    endfunction

    function automatic void rotate(input logic [31:0] ang, output longint s,
                                   output longint c);
        logic [31:0] q, ru;
        longint x, y, z, xs, ys;
        q  = ((ang + 32'h2000_0000) >> 30) & 32'd3;
        ru = ang - (q << 30);
        z  = longint'($signed(ru));
        x  = GAIN_Q30;
        y  = 0;
        for (int i = 0; i < 28; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < 28; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        if (z < 0) z = 0;
        if (z > UNIT_Q30) z = UNIT_Q30;
        return z;
    endfunction

    function automatic logic [30:0] great_circle_km(longint la, longint oa,
                                                    longint lb, longint ob);
        longint sd, cd, so, co, s1, c1, s2, c2, hav, sy, sx, half_ang;
        logic [63:0] km_q16;
        rotate(deg_to_turn(lb - la, HALF_FACTOR), sd, cd);
        rotate(deg_to_turn(ob - oa, HALF_FACTOR), so, co);
        rotate(deg_to_turn(la, FULL_FACTOR), s1, c1);
        rotate(deg_to_turn(lb, FULL_FACTOR), s2, c2);
        hav = rshift(sd * sd, 30)
            + rshift(rshift(c1 * c2, 30) * rshift(so * so, 30), 30);
        if (hav < 0) hav = 0;
        if (hav > UNIT_Q30) hav = UNIT_Q30;
        sy = int_sqrt(64'(hav) << 30);
        sx = int_sqrt(64'(UNIT_Q30 - hav) << 30);
        half_ang = vector_angle(sy, sx);
        km_q16 = (64'(half_ang) * hvd_pkg::DIST_SCALE + (64'd1 << 31)) >> 32;
        if (km_q16 > 64'(hvd_pkg::DIST_MAX)) km_q16 = 64'(hvd_pkg::DIST_MAX);
        return km_q16[30:0];
    endfunction

    // predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin
        logic [30:0] want;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                dist_queue = {dist_queue,
                              great_circle_km(i_lat_a, i_lon_a, i_lat_b, i_lon_b)};
            if (o_valid && !i_stall) begin
                if (dist_queue.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %0d",
                             $time, o_distance_km);
                    o_errors++;
                end else begin
                    want = dist_queue.pop_front();
                    if (want !== o_distance_km) begin
                        $display("%0t: distance_km mismatch, expected %0d, actual %0d",
                                 $time, want, o_distance_km);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = dist_queue.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

endmodule

>>> tb/tb_haversine_distance.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haversine_distance
// Drives directed and random coordinate pairs into the haversine distance
// pipeline with random idling on both sides; the checker predicts and
// compares every distance.
// ----------------------------------------------------------------------------
module tb_haversine_distance;

    localparam int LAT_MAX = 94371840;
    localparam int LON_MAX = 188743680;
    localparam int N_RANDOM = 1750;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [27:0] i_lat_a;
    logic signed [28:0] i_lon_a;
    logic signed [27:0] i_lat_b;
    logic signed [28:0] i_lon_b;
    logic               o_valid;
    logic               i_stall;
    logic [30:0]        o_distance_km;
    int                 errors;
    int                 pending;
    bit                 calm;

    haversine_distance i_dut (.*);

    hvd_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall, .i_lat_a, .i_lon_a, .i_lat_b,
        .i_lon_b, .o_valid, .o_stall, .o_distance_km,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output stall in random bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // present one item and hold it until accepted
    task automatic send_pair(input logic [27:0] la, input logic [28:0] oa,
                             input logic [27:0] lb, input logic [28:0] ob);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_lat_a <= la;
        i_lon_a <= oa;
        i_lat_b <= lb;
        i_lon_b <= ob;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [27:0] rand_lat(int mode);
        case (mode)
            0: return 28'($urandom);
            1: return 28'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
            default: return 28'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [28:0] rand_lon(int mode);
        case (mode)
            0: return 29'($urandom);
            1: return 29'($signed($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
            default: return 29'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    initial begin
        logic [27:0] la;
        logic [28:0] oa;
        int m;
        calm    = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_lat_a = '0;
        i_lon_a = '0;
        i_lat_b = '0;
        i_lon_b = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero distance, poles, antipodes, field extremes, wrap
        send_pair(28'(0), 29'(0), 28'(0), 29'(0));
        send_pair(28'(LAT_MAX), 29'(0), 28'(-LAT_MAX), 29'(0));
        send_pair(28'(0), 29'(0), 28'(0), 29'(LON_MAX));
        send_pair(28'(0), 29'(-LON_MAX), 28'(0), 29'(LON_MAX));
        send_pair(28'(LAT_MAX / 2), 29'(LON_MAX / 3), 28'(-LAT_MAX / 2),
                  29'(LON_MAX / 3 - LON_MAX));
        send_pair(28'(LAT_MAX), 29'(LON_MAX), 28'(LAT_MAX), 29'(-LON_MAX));
        send_pair(28'h7ff_ffff, 29'h0fff_ffff, 28'h800_0000, 29'h1000_0000);
        send_pair(28'h800_0000, 29'h1000_0000, 28'h7ff_ffff, 29'h0fff_ffff);
        send_pair(28'hfff_ffff, 29'h1fff_ffff, 28'(0), 29'(0));
        send_pair(28'(1), 29'(1), 28'(0), 29'(0));
        send_pair(28'(LAT_MAX), 29'(0), 28'(LAT_MAX), 29'(1));
        send_pair(28'(0), 29'(0), 28'sd100000000, 29'sd200000000);
        send_pair(28'(-LAT_MAX), 29'(-LON_MAX), 28'(-LAT_MAX), 29'(-LON_MAX));
        send_pair(28'(12345678), 29'(-98765432), 28'(-12345678),
                  29'(98765432 - LON_MAX));

        // hold off until the pipeline has drained
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200) calm = 1'b1;
            m  = $urandom_range(0, 5);
            la = rand_lat(m == 0 ? 0 : 1);
            oa = rand_lon(m == 0 ? 0 : 1);
            case (m)
                2: send_pair(la, oa, la + rand_lat(2), oa + rand_lon(2));
                3: send_pair(la, oa, -la, oa + 29'(LON_MAX) + rand_lon(2));
                default: send_pair(la, oa, rand_lat(m == 0 ? 0 : 1),
                                   rand_lon(m == 0 ? 0 : 1));
            endcase
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (110) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> haversine_distance.f
rtl/hvd_pkg.sv
rtl/hvd_sincos.sv
rtl/hvd_isqrt.sv
rtl/hvd_atan.sv
rtl/haversine_distance.sv
tb/hvd_checker.sv
tb/tb_haversine_distance.sv
